FILE: rtl/encoder_speed_pid_four_motor_macros.svh
// Assertion macros used by the checker file.
`ifndef ENCODER_SPEED_PID_FOUR_MOTOR_MACROS_SVH
`define ENCODER_SPEED_PID_FOUR_MOTOR_MACROS_SVH
// Same-cycle implication, disabled in reset.
`define ESPM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define ESPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
// Condition that must hold in the cycle after reset.
`define ESPM_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/espm_pkg.sv
// Types, constants and helpers of the four-motor speed PID block.
package espm_pkg;
  localparam int MOTOR_SLOTS = 4;
  localparam int FRAC_BITS = 24;
  localparam int NUMER_W = 30;
  localparam logic [NUMER_W-1:0] SPEED_NUMER = 30'd1000000000;
  localparam logic [15:0] SPEED_SAT = 16'hFFFF;
  localparam logic [33:0] INTEG_LIMIT = 34'd1023 << FRAC_BITS;
  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT = 4'd0,
    CFG_GAIN_P   = 4'd1,
    CFG_GAIN_I   = 4'd2,
    CFG_GAIN_D   = 4'd3,
    CFG_PULSES_A = 4'd4,
    CFG_PULSES_B = 4'd5,
    CFG_PULSES_C = 4'd6,
    CFG_PULSES_D = 4'd7
  } cfg_idx_t;

  typedef enum logic {
    KIND_EDGE = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef struct packed {
    logic [15:0]      setpoint;
    logic [31:0]      gain_p;
    logic [31:0]      gain_i;
    logic [31:0]      gain_d;
    logic [3:0][11:0] pulses;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  sel;
    logic [15:0] stamp;
  } item_t;

  function automatic logic [1:0] chan_of_motor(input logic [1:0] m);
    logic [1:0] c;
    case (m)
      2'd0: c = 2'd3;
      2'd1: c = 2'd1;
      2'd2: c = 2'd0;
      default: c = 2'd2;
    endcase
    return c;
  endfunction
endpackage

FILE: rtl/espm_if.sv
// Valid/ready channel interfaces for encoder/tick items and duty results.
interface espm_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [1:0]  motor_sel;
  logic [15:0] edge_stamp;
  modport source (output valid, func, motor_sel, edge_stamp, input ready);
  modport sink (input valid, func, motor_sel, edge_stamp, output ready);
endinterface

interface espm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] pwm_channel;
  logic [9:0] duty_value;
  logic       last_of_tick;
  modport source (output valid, pwm_channel, duty_value, last_of_tick, input ready);
  modport sink (input valid, pwm_channel, duty_value, last_of_tick, output ready);
endinterface

FILE: rtl/espm_front.sv
// Front end: accept and classify items into a two-entry queue.
module espm_front import espm_pkg::*; #(
  parameter int NUM_MOTORS = 4
) (
  input  logic   clk,
  input  logic   rst,
  espm_in_if.sink in_ch,
  output logic   q_valid,
  output item_t  q_item,
  input  logic   q_pop
);
  localparam int N_ACT = (NUM_MOTORS > MOTOR_SLOTS) ? MOTOR_SLOTS : NUM_MOTORS;

  item_t      slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       accept, keep, push;

  assign in_ch.ready = (count != 2'd2);
  assign accept = in_ch.valid && in_ch.ready;
  // drop edges on motors that are not fitted
  assign keep = in_ch.func || ({1'b0, in_ch.motor_sel} < 3'(N_ACT));
  assign push = accept && keep;
  assign q_valid = (count != 2'd0);
  assign q_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{kind: kind_t'(in_ch.func), sel: in_ch.motor_sel,
                         stamp: in_ch.edge_stamp};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end
endmodule

FILE: rtl/espm_div.sv
// Restoring divider of the fixed speed numerator, one quotient bit a cycle.
module espm_div import espm_pkg::*; #(
  parameter int DEN_W = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DEN_W-1:0]   den,
  output logic               done,
  output logic [NUMER_W-1:0] quot
);
  localparam int CNT_W = $clog2(NUMER_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] divisor, rem;
  logic [DEN_W:0]   rem_sh;

  assign rem_sh = {rem, SPEED_NUMER[cnt]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(NUMER_W - 1);
        rem <= '0;
        divisor <= den;
      end else if (busy) begin
        if (rem_sh >= {1'b0, divisor}) begin
          rem <= DEN_W'(rem_sh - {1'b0, divisor});
          quot <= {quot[NUMER_W-2:0], 1'b1};
        end else begin
          rem <= DEN_W'(rem_sh);
          quot <= {quot[NUMER_W-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end
endmodule

FILE: rtl/espm_back.sv
// Back end: speed update per edge and the PID sequence per tick.
module espm_back import espm_pkg::*; #(
  parameter int NUM_MOTORS = 4,
  parameter int DUTY_MAX = 1023,
  parameter int TICK_SCALE = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  espm_out_if.source out_ch
);
  localparam int N_ACT = (NUM_MOTORS > MOTOR_SLOTS) ? MOTOR_SLOTS : NUM_MOTORS;
  localparam int PER_W = 16 + $clog2(TICK_SCALE + 1);
  localparam int DEN_W = 12 + PER_W;
  localparam int PROD_W = 51;
  localparam int I_W = 52;
  localparam int SUM_W = 54;
  localparam logic signed [SUM_W-1:0] DUTY_TOP = SUM_W'(DUTY_MAX) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_DEN, S_DIV, S_ERR, S_MP, S_MI, S_MD, S_INT, S_SUM, S_EMIT
  } state_t;

  state_t state;
  logic [1:0]  sel, m;
  logic [15:0] stamp;
  logic [PER_W-1:0] period;
  logic [DEN_W-1:0] den;
  logic        div_start, div_done;
  logic [NUMER_W-1:0] quot;

  logic [15:0] speed [MOTOR_SLOTS];
  logic [15:0] pstamp [MOTOR_SLOTS];
  logic [33:0] integ [MOTOR_SLOTS];
  logic signed [16:0] perr [MOTOR_SLOTS];

  logic signed [16:0] err, err_new;
  logic signed [17:0] diff;
  logic signed [17:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [PROD_W-1:0] prod, p_reg, ip_reg, d_reg;
  logic signed [I_W-1:0] isum;
  logic [33:0] i_clamp, i_reg;
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0] duty_full;
  logic [9:0] duty;

  assign q_pop = (state == S_IDLE) && q_valid;
  assign den = DEN_W'(cfg.pulses[sel]) * DEN_W'(period);
  assign div_start = (state == S_DEN) && (den != '0);

  espm_div #(.DEN_W(DEN_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .den(den),
    .done(div_done), .quot(quot)
  );

  assign err_new = $signed({1'b0, cfg.setpoint}) - $signed({1'b0, speed[m]});

  // one shared multiplier, one product per state
  always_comb begin
    case (state)
      S_MD: begin
        mul_a = diff;
        mul_b = $signed({1'b0, cfg.gain_d});
      end
      S_MI: begin
        mul_a = 18'(err);
        mul_b = $signed({1'b0, cfg.gain_i});
      end
      default: begin
        mul_a = 18'(err);
        mul_b = $signed({1'b0, cfg.gain_p});
      end
    endcase
  end
  assign prod = PROD_W'(mul_a * mul_b);

  assign isum = I_W'($signed({1'b0, integ[m]})) + I_W'(ip_reg);
  always_comb begin
    if (isum < 0) i_clamp = '0;
    else if (isum > I_W'($signed({1'b0, INTEG_LIMIT}))) i_clamp = INTEG_LIMIT;
    else i_clamp = 34'(isum);
  end

  assign sum = SUM_W'(p_reg) + SUM_W'($signed({1'b0, i_reg})) + SUM_W'(d_reg);
  always_comb begin
    if (sum < 0) duty_full = '0;
    else if (sum > DUTY_TOP) duty_full = SUM_W'(DUTY_MAX);
    else duty_full = SUM_W'(sum >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_ch.valid <= 1'b0;
      for (int k = 0; k < MOTOR_SLOTS; k++) begin
        speed[k] <= '0;
        pstamp[k] <= '0;
        integ[k] <= '0;
        perr[k] <= '0;
      end
    end else begin
      // drop a taken duty; the emit state reloads or holds it itself
      if (out_ch.valid && out_ch.ready && (state != S_EMIT)) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            sel <= q_item.sel;
            stamp <= q_item.stamp;
            m <= 2'd0;
            period <= PER_W'(16'(q_item.stamp - pstamp[q_item.sel])) * PER_W'(TICK_SCALE);
            state <= (q_item.kind == KIND_TICK) ? S_ERR : S_DEN;
          end
        end
        S_DEN: begin
          // zero divisor saturates at once
          if (den == '0) begin
            speed[sel] <= SPEED_SAT;
            pstamp[sel] <= stamp;
            state <= S_IDLE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            speed[sel] <= (quot > NUMER_W'(SPEED_SAT)) ? SPEED_SAT : quot[15:0];
            pstamp[sel] <= stamp;
            state <= S_IDLE;
          end
        end
        S_ERR: begin
          err <= err_new;
          diff <= 18'(err_new) - 18'(perr[m]);
          state <= S_MP;
        end
        S_MP: begin
          p_reg <= prod;
          state <= S_MI;
        end
        S_MI: begin
          ip_reg <= prod;
          state <= S_MD;
        end
        S_MD: begin
          d_reg <= prod;
          state <= S_INT;
        end
        S_INT: begin
          i_reg <= i_clamp;
          integ[m] <= i_clamp;
          state <= S_SUM;
        end
        S_SUM: begin
          duty <= duty_full[9:0];
          perr[m] <= err;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            out_ch.pwm_channel <= chan_of_motor(m);
            out_ch.duty_value <= duty;
            out_ch.last_of_tick <= (m == 2'(N_ACT - 1));
            if (m == 2'(N_ACT - 1)) begin
              state <= S_IDLE;
            end else begin
              m <= m + 1'b1;
              state <= S_ERR;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/encoder_speed_pid_four_motor.sv
// Top level of the four-motor encoder speed measurement and PID block.
//
//   channel | direction | transaction
//   in_ch   | sink      | encoder edge (func 0) or control tick (func 1)
//   out_ch  | source    | one duty per motor, last_of_tick on the final one
//   cfg     | write     | cfg_we / cfg_index / cfg_data, no read-back
//
// An edge item runs the restoring divider of the speed numerator, which
// resolves one quotient bit per cycle; a zero divisor saturates at once.
// A tick item runs, for each motor, the error step, then the PID terms on
// one shared multiplier, one term per cycle, then the integral clamp, sum
// and emit.
// Synchronous reset clears the config to its defaults and all motor state.
// The two-entry queue keeps accepting while the back end works or while a
// duty waits at the output register, until both entries fill; a stalled
// output holds the PID in its emit step.
module encoder_speed_pid_four_motor import espm_pkg::*; #(
  parameter int NUM_MOTORS = 4,
  parameter int DUTY_MAX = 1023,
  parameter int TICK_SCALE = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  espm_in_if.sink              in_ch,
  espm_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);
  cfg_t  cfg;
  logic  q_valid, q_pop;
  item_t q_item;

  // Hold the register file; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint <= 16'd500;
      cfg.gain_p <= 32'd1056125747;
      cfg.gain_i <= 32'd16056;
      cfg.gain_d <= 32'd4;
      cfg.pulses[0] <= 12'd1000;
      cfg.pulses[1] <= 12'd460;
      cfg.pulses[2] <= 12'd630;
      cfg.pulses[3] <= 12'd640;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SETPOINT: cfg.setpoint <= cfg_data[15:0];
        CFG_GAIN_P:   cfg.gain_p <= cfg_data;
        CFG_GAIN_I:   cfg.gain_i <= cfg_data;
        CFG_GAIN_D:   cfg.gain_d <= cfg_data;
        CFG_PULSES_A: cfg.pulses[0] <= cfg_data[11:0];
        CFG_PULSES_B: cfg.pulses[1] <= cfg_data[11:0];
        CFG_PULSES_C: cfg.pulses[2] <= cfg_data[11:0];
        CFG_PULSES_D: cfg.pulses[3] <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Accept and classify; drop edges for motors not fitted.
  espm_front #(.NUM_MOTORS(NUM_MOTORS)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  // Carry out speed updates and PID runs.
  espm_back #(
    .NUM_MOTORS(NUM_MOTORS), .DUTY_MAX(DUTY_MAX), .TICK_SCALE(TICK_SCALE)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .out_ch(out_ch)
  );
endmodule

FILE: rtl/espm_checker.sv
// Port-level checker of the speed PID block and its bind.
`include "encoder_speed_pid_four_motor_macros.svh"
module espm_checker import espm_pkg::*; #(
  parameter int NUM_MOTORS = 4
) (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] pwm_channel,
  input logic [9:0] duty_value,
  input logic       last_of_tick
);
  localparam int N_ACT = (NUM_MOTORS > MOTOR_SLOTS) ? MOTOR_SLOTS : NUM_MOTORS;
  localparam logic [1:0] LAST_CHAN = chan_of_motor(2'(N_ACT - 1));

  `ESPM_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(duty_value) && $stable(pwm_channel) && $stable(last_of_tick))
  `ESPM_ASSERT_SAME(a_last_chan, out_valid && last_of_tick, pwm_channel == LAST_CHAN)
  `ESPM_ASSERT_SAME(a_not_last, out_valid && !last_of_tick, pwm_channel != LAST_CHAN)
  `ESPM_ASSERT_RST(a_rst_idle, !out_valid)
endmodule

bind encoder_speed_pid_four_motor espm_checker #(.NUM_MOTORS(NUM_MOTORS)) u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .pwm_channel(out_ch.pwm_channel), .duty_value(out_ch.duty_value),
  .last_of_tick(out_ch.last_of_tick)
);
